>>> hw/rtl/rmte_pkg.sv
package rmte_pkg;

    localparam int COMP_W    = 16;
    localparam int EPS_W     = 14;
    localparam int ANGLE_W   = 15;
    localparam int ACOS_W    = 14;

    localparam int SQRT_STEPS = 16;
    localparam int SQ_OP_W    = 32;
    localparam int SQ_REM_W   = 20;
    localparam int SQ_ROOT_W  = 16;

    localparam int DIV_BITS  = 15;
    localparam int DIV_W     = 33;
    localparam int DEN_W     = 18;

    localparam int CX_W      = 36;
    localparam int CZ_W      = 26;
    localparam int ATAN_W    = 22;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [14:0] ONE_Q14      = 15'd16384;
    localparam logic [31:0] ONE_SQ_Q28   = 32'd268435456;
    localparam logic [23:0] QUARTER_TURN = 24'd5898240;
    localparam logic [23:0] HALF_TURN    = 24'd11796480;
    localparam logic [24:0] ROUND_HALF   = 25'd512;
    localparam logic [ANGLE_W-1:0] LOCK_BETA = 15'd5760;

    function automatic logic [ATAN_W-1:0] atan_deg(input int idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            0:       val = 22'd2949120;
            1:       val = 22'd1740967;
            2:       val = 22'd919879;
            3:       val = 22'd466945;
            4:       val = 22'd234379;
            5:       val = 22'd117304;
            6:       val = 22'd58666;
            7:       val = 22'd29335;
            8:       val = 22'd14668;
            9:       val = 22'd7334;
            10:      val = 22'd3667;
            11:      val = 22'd1833;
            12:      val = 22'd917;
            13:      val = 22'd458;
            14:      val = 22'd229;
            15:      val = 22'd115;
            16:      val = 22'd57;
            17:      val = 22'd29;
            18:      val = 22'd14;
            19:      val = 22'd7;
            20:      val = 22'd4;
            21:      val = 22'd2;
            22:      val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/rmte_matrix_if.sv
interface rmte_matrix_if;
    logic                                valid;
    logic                                ready;
    logic signed [rmte_pkg::COMP_W-1:0] first_x;
    logic signed [rmte_pkg::COMP_W-1:0] first_y;
    logic signed [rmte_pkg::COMP_W-1:0] first_z;
    logic signed [rmte_pkg::COMP_W-1:0] second_x;
    logic signed [rmte_pkg::COMP_W-1:0] second_y;
    logic signed [rmte_pkg::COMP_W-1:0] second_z;
    logic signed [rmte_pkg::COMP_W-1:0] third_x;
    logic signed [rmte_pkg::COMP_W-1:0] third_y;
    logic signed [rmte_pkg::COMP_W-1:0] third_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        output ready
    );
endinterface

>>> hw/rtl/rmte_angles_if.sv
interface rmte_angles_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 ok;
    logic signed [rmte_pkg::ANGLE_W-1:0] angle_x;
    logic signed [rmte_pkg::ANGLE_W-1:0] angle_y;
    logic signed [rmte_pkg::ANGLE_W-1:0] angle_z;

    modport source (
        output valid, ok, angle_x, angle_y, angle_z,
        input  ready
    );
    modport sink (
        input  valid, ok, angle_x, angle_y, angle_z,
        output ready
    );
endinterface

>>> hw/rtl/rmte_sqrt_cell.sv
module rmte_sqrt_cell (
    input  logic                               clk,
    input  logic                               en,
    input  logic [rmte_pkg::SQ_OP_W-1:0]       op_in,
    input  logic [rmte_pkg::SQ_REM_W-1:0]      rem_in,
    input  logic [rmte_pkg::SQ_ROOT_W-1:0]     root_in,
    output logic [rmte_pkg::SQ_OP_W-1:0]       op_out,
    output logic [rmte_pkg::SQ_REM_W-1:0]      rem_out,
    output logic [rmte_pkg::SQ_ROOT_W-1:0]     root_out
);

    localparam int OW = rmte_pkg::SQ_OP_W;
    localparam int RW = rmte_pkg::SQ_REM_W;
    localparam int TW = rmte_pkg::SQ_ROOT_W;

    logic [OW-1:0] op_reg,   op_next;
    logic [RW-1:0] rem_reg,  rem_next;
    logic [TW-1:0] root_reg, root_next;
    logic [RW-1:0] rem_sh;
    logic [RW:0]   trial;

    always_comb
    begin
        rem_sh  = {rem_in[RW-3:0], op_in[OW-1:OW-2]};
        trial   = {1'b0, rem_sh} - (RW+1)'({root_in, 2'b01});
        op_next = {op_in[OW-3:0], 2'b00};
        if (!trial[RW])
        begin
            rem_next  = trial[RW-1:0];
            root_next = {root_in[TW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_in[TW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg   <= op_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign op_out   = op_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

>>> hw/rtl/rmte_div_cell.sv
module rmte_div_cell #(
    parameter int K = 0
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [rmte_pkg::DIV_W-1:0]        rem_in,
    input  logic [rmte_pkg::DEN_W-1:0]        den_in,
    input  logic [rmte_pkg::DIV_BITS-1:0]     quo_in,
    output logic [rmte_pkg::DIV_W-1:0]        rem_out,
    output logic [rmte_pkg::DEN_W-1:0]        den_out,
    output logic [rmte_pkg::DIV_BITS-1:0]     quo_out
);

    localparam int DW = rmte_pkg::DIV_W;

    logic [DW-1:0]                    rem_reg, rem_next;
    logic [rmte_pkg::DEN_W-1:0]       den_reg;
    logic [rmte_pkg::DIV_BITS-1:0]    quo_reg, quo_next;
    logic [DW-1:0]                    dsh;

    always_comb
    begin
        dsh      = DW'(den_in) << K;
        rem_next = rem_in;
        quo_next = quo_in;
        if (rem_in >= dsh)
        begin
            rem_next    = rem_in - dsh;
            quo_next[K] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

>>> hw/rtl/rmte_cordic_cell.sv
module rmte_cordic_cell #(
    parameter int I = 0
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [rmte_pkg::CX_W-1:0]    x_in,
    input  logic signed [rmte_pkg::CX_W-1:0]    y_in,
    input  logic signed [rmte_pkg::CZ_W-1:0]    z_in,
    output logic signed [rmte_pkg::CX_W-1:0]    x_out,
    output logic signed [rmte_pkg::CX_W-1:0]    y_out,
    output logic signed [rmte_pkg::CZ_W-1:0]    z_out
);

    localparam int XW = rmte_pkg::CX_W;
    localparam int ZW = rmte_pkg::CZ_W;
    localparam logic signed [ZW-1:0] ATAN = ZW'(rmte_pkg::atan_deg(I));

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next;

    always_comb
    begin
        xs = x_in >>> I;
        ys = y_in >>> I;
        if (y_in > 0)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

>>> hw/rtl/rotation_matrix_to_euler_angles.sv
// Rotation matrix to XYZ Euler angles.
// matrix: request of three basis vectors, signed Q1.14, taken when valid and
//   ready are both high. angles: ok flag and alpha/beta/gamma in 1/64 degree,
//   all zero when the matrix is rejected.
// cfg_we/cfg_wdata write epsilon (Q1.14 units); write only while idle.
// The path runs in turn through three 16-cell square-root chains, two
//   15-cell divider chains and the CORDIC chain of one cell per step, plus
//   single-stage products and checks.
// Throughput: one request per cycle. Every stage moves together; when the
//   receiver holds ready low with a result waiting, the whole chain holds and
//   matrix.ready drops, otherwise a new request is taken every cycle.
// Reset clears the valid bits of the chain and sets epsilon to 2; no
//   clearing pass is needed.
module rotation_matrix_to_euler_angles #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rmte_pkg::EPS_W-1:0]    cfg_wdata,
    rmte_matrix_if.sink                   matrix,
    rmte_angles_if.source                 angles
);

    localparam int SQ   = rmte_pkg::SQRT_STEPS;
    localparam int DB   = rmte_pkg::DIV_BITS;
    localparam int DW   = rmte_pkg::DIV_W;
    localparam int NW   = rmte_pkg::DEN_W;
    localparam int OW   = rmte_pkg::SQ_OP_W;
    localparam int RW   = rmte_pkg::SQ_REM_W;
    localparam int TW   = rmte_pkg::SQ_ROOT_W;
    localparam int XW   = rmte_pkg::CX_W;
    localparam int ZW   = rmte_pkg::CZ_W;
    localparam int AW   = rmte_pkg::ANGLE_W;
    localparam int LAT  = 92 + CORDIC_STEPS;

    typedef logic [8:0][15:0] mat_t;

    typedef struct packed {
        logic bad;
        logic lock;
        logic n1y_neg;
        logic n1z_neg;
        logic n1z_zero;
        logic n2x_neg;
        logic n2x_zero;
        logic n2z_neg;
    } flg_t;

    typedef struct packed {
        mat_t n;
        logic bad;
    } nside_t;

    typedef struct packed {
        flg_t        f;
        logic [15:0] h;
        logic [15:0] n2y;
        logic [1:0]  neg;
        logic [1:0]  ovf;
    } dside_t;

    typedef struct packed {
        flg_t             f;
        logic [2:0][14:0] mag;
        logic [2:0]       cneg;
    } aside_t;

    typedef struct packed {
        flg_t       f;
        logic [2:0] cneg;
    } cside_t;

    logic                   en;
    logic [LAT-1:0]         vld_reg;
    logic [13:0]            eps_reg;

    assign en           = !vld_reg[LAT-1] || angles.ready;
    assign matrix.ready = en;
    assign angles.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            eps_reg <= 14'd2;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[LAT-2:0], matrix.valid};
            if (cfg_we)
                eps_reg <= cfg_wdata;
        end
    end

    // input, squares, sums
    mat_t               v_reg, v2_reg, v3_reg;
    logic [8:0][30:0]   sq_reg;
    logic [2:0][31:0]   sum_reg;
    logic signed [31:0] prod_v [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            prod_v[i] = $signed(v_reg[i]) * $signed(v_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= {matrix.third_z, matrix.third_y, matrix.third_x,
                      matrix.second_z, matrix.second_y, matrix.second_x,
                      matrix.first_z, matrix.first_y, matrix.first_x};
            for (int i = 0; i < 9; i++)
                sq_reg[i] <= prod_v[i][30:0];
            v2_reg <= v_reg;
            for (int k = 0; k < 3; k++)
                sum_reg[k] <= 32'(sq_reg[3*k]) + 32'(sq_reg[3*k+1]) + 32'(sq_reg[3*k+2]);
            v3_reg <= v2_reg;
        end
    end

    // vector lengths
    logic [OW-1:0] s1_op   [3][SQ+1];
    logic [RW-1:0] s1_rem  [3][SQ+1];
    logic [TW-1:0] s1_root [3][SQ+1];
    mat_t          va_reg  [SQ];

    for (genvar k = 0; k < 3; k++)
    begin : g_len
        assign s1_op[k][0]   = sum_reg[k];
        assign s1_rem[k][0]  = '0;
        assign s1_root[k][0] = '0;
        for (genvar i = 0; i < SQ; i++)
        begin : g_cell
            rmte_sqrt_cell u_cell (
                .clk      (clk),
                .en       (en),
                .op_in    (s1_op[k][i]),
                .rem_in   (s1_rem[k][i]),
                .root_in  (s1_root[k][i]),
                .op_out   (s1_op[k][i+1]),
                .rem_out  (s1_rem[k][i+1]),
                .root_out (s1_root[k][i+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            va_reg[0] <= v3_reg;
            for (int i = 1; i < SQ; i++)
                va_reg[i] <= va_reg[i-1];
        end
    end

    // normalise
    logic [DW-1:0] p1_num_reg [9];
    logic [NW-1:0] p1_den_reg [9];
    logic [9:0]    p1_side_reg;
    logic [DW-1:0] p1_num_next [9];
    logic [NW-1:0] p1_den_next [9];
    logic [9:0]    p1_side_next;

    always_comb
    begin
        logic [TW-1:0] len;
        logic [TW-1:0] den;
        logic [16:0]   vs;
        logic [15:0]   vabs;
        p1_side_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            len = s1_root[k][SQ];
            den = (len == '0) ? TW'(1) : len;
            if (len <= TW'(eps_reg))
                p1_side_next[9] = 1'b1;
            for (int j = 0; j < 3; j++)
            begin
                vs   = {va_reg[SQ-1][3*k+j][15], va_reg[SQ-1][3*k+j]};
                vabs = vs[16] ? 16'(-vs) : vs[15:0];
                p1_side_next[3*k+j] = vs[16];
                p1_num_next[3*k+j]  = DW'({vabs, 15'b0}) + DW'(len);
                p1_den_next[3*k+j]  = NW'({den, 1'b0});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_num_reg  <= p1_num_next;
            p1_den_reg  <= p1_den_next;
            p1_side_reg <= p1_side_next;
        end
    end

    logic [DW-1:0] d1_rem [9][DB+1];
    logic [NW-1:0] d1_den [9][DB+1];
    logic [DB-1:0] d1_quo [9][DB+1];
    logic [9:0]    d1_side_reg [DB];

    for (genvar c = 0; c < 9; c++)
    begin : g_norm
        assign d1_rem[c][0] = p1_num_reg[c];
        assign d1_den[c][0] = p1_den_reg[c];
        assign d1_quo[c][0] = '0;
        for (genvar i = 0; i < DB; i++)
        begin : g_cell
            rmte_div_cell #(.K(DB-1-i)) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (d1_rem[c][i]),
                .den_in  (d1_den[c][i]),
                .quo_in  (d1_quo[c][i]),
                .rem_out (d1_rem[c][i+1]),
                .den_out (d1_den[c][i+1]),
                .quo_out (d1_quo[c][i+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_side_reg[0] <= p1_side_reg;
            for (int i = 1; i < DB; i++)
                d1_side_reg[i] <= d1_side_reg[i-1];
        end
    end

    // normalised vectors, dot products, horizontal length
    mat_t               n_reg, m_n_reg, dn_reg;
    logic               n_bad_reg, m_bad_reg, dn_bad_reg;
    logic signed [31:0] pp_reg [3][3];
    logic [31:0]        hq_reg [2];
    logic [31:0]        hs_reg;
    logic signed [31:0] pp_next [3][3];
    logic signed [31:0] hq_next [2];
    logic               dot_bad;

    always_comb
    begin
        logic signed [33:0] dot;
        logic [33:0]        dabs;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                pp_next[i][j] = $signed(n_reg[3*i+j]) * $signed(n_reg[3*((i+1)%3)+j]);
        hq_next[0] = $signed(n_reg[0]) * $signed(n_reg[0]);
        hq_next[1] = $signed(n_reg[1]) * $signed(n_reg[1]);
        dot_bad = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            dot  = 34'(pp_reg[i][0]) + 34'(pp_reg[i][1]) + 34'(pp_reg[i][2]);
            dabs = dot[33] ? 34'(-dot) : 34'(dot);
            if (dabs > 34'({eps_reg, 14'b0}))
                dot_bad = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 9; c++)
                n_reg[c] <= d1_side_reg[DB-1][c] ? 16'(-{1'b0, d1_quo[c][DB]})
                                                 : 16'({1'b0, d1_quo[c][DB]});
            n_bad_reg <= d1_side_reg[DB-1][9];
            pp_reg    <= pp_next;
            hq_reg[0] <= hq_next[0];
            hq_reg[1] <= hq_next[1];
            m_n_reg   <= n_reg;
            m_bad_reg <= n_bad_reg;
            hs_reg    <= hq_reg[0] + hq_reg[1];
            dn_reg    <= m_n_reg;
            dn_bad_reg <= m_bad_reg || dot_bad;
        end
    end

    logic [OW-1:0] s2_op   [SQ+1];
    logic [RW-1:0] s2_rem  [SQ+1];
    logic [TW-1:0] s2_root [SQ+1];
    nside_t        s2_side_reg [SQ];

    assign s2_op[0]   = hs_reg;
    assign s2_rem[0]  = '0;
    assign s2_root[0] = '0;

    for (genvar i = 0; i < SQ; i++)
    begin : g_hlen
        rmte_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .op_in    (s2_op[i]),
            .rem_in   (s2_rem[i]),
            .root_in  (s2_root[i]),
            .op_out   (s2_op[i+1]),
            .rem_out  (s2_rem[i+1]),
            .root_out (s2_root[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_side_reg[0] <= '{n: dn_reg, bad: dn_bad_reg};
            for (int i = 1; i < SQ; i++)
                s2_side_reg[i] <= s2_side_reg[i-1];
        end
    end

    // cosine ratios against the horizontal length
    logic [DW-1:0] p2_num_reg [2];
    logic [NW-1:0] p2_den_reg [2];
    dside_t        p2_side_reg;
    logic [DW-1:0] p2_num_next [2];
    logic [NW-1:0] p2_den_next [2];
    dside_t        p2_side_next;

    always_comb
    begin
        logic [TW-1:0] h;
        logic [TW-1:0] hd;
        logic [15:0]   nv;
        logic [15:0]   nabs;
        mat_t          nn;
        nn = s2_side_reg[SQ-1].n;
        h  = s2_root[SQ];
        hd = (h == '0) ? TW'(1) : h;
        p2_side_next.f.bad      = s2_side_reg[SQ-1].bad;
        p2_side_next.f.lock     = (h < TW'(eps_reg)) || (h == '0);
        p2_side_next.f.n1y_neg  = nn[1][15];
        p2_side_next.f.n1z_neg  = nn[2][15];
        p2_side_next.f.n1z_zero = (nn[2] == '0);
        p2_side_next.f.n2x_neg  = nn[3][15];
        p2_side_next.f.n2x_zero = (nn[3] == '0);
        p2_side_next.f.n2z_neg  = nn[5][15];
        p2_side_next.h          = h;
        p2_side_next.n2y        = nn[4];
        for (int r = 0; r < 2; r++)
        begin
            nv   = (r == 0) ? nn[0] : nn[8];
            nabs = nv[15] ? 16'(-nv) : nv;
            p2_num_next[r] = DW'({nabs, 15'b0}) + DW'(hd);
            p2_den_next[r] = NW'({hd, 1'b0});
            p2_side_next.neg[r] = nv[15];
            p2_side_next.ovf[r] = p2_num_next[r] >= (DW'(p2_den_next[r]) << DB);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_num_reg  <= p2_num_next;
            p2_den_reg  <= p2_den_next;
            p2_side_reg <= p2_side_next;
        end
    end

    logic [DW-1:0] d2_rem [2][DB+1];
    logic [NW-1:0] d2_den [2][DB+1];
    logic [DB-1:0] d2_quo [2][DB+1];
    dside_t        d2_side_reg [DB];

    for (genvar c = 0; c < 2; c++)
    begin : g_ratio
        assign d2_rem[c][0] = p2_num_reg[c];
        assign d2_den[c][0] = p2_den_reg[c];
        assign d2_quo[c][0] = '0;
        for (genvar i = 0; i < DB; i++)
        begin : g_cell
            rmte_div_cell #(.K(DB-1-i)) u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (d2_rem[c][i]),
                .den_in  (d2_den[c][i]),
                .quo_in  (d2_quo[c][i]),
                .rem_out (d2_rem[c][i+1]),
                .den_out (d2_den[c][i+1]),
                .quo_out (d2_quo[c][i+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_side_reg[0] <= p2_side_reg;
            for (int i = 1; i < DB; i++)
                d2_side_reg[i] <= d2_side_reg[i-1];
        end
    end

    // cosine selection: unit 0 gamma, 1 beta, 2 alpha
    logic signed [16:0] cos_reg [3];
    logic signed [16:0] cos_next [3];
    flg_t               cf_reg;

    always_comb
    begin
        logic [16:0] rv [2];
        dside_t      sd;
        sd = d2_side_reg[DB-1];
        for (int r = 0; r < 2; r++)
        begin
            rv[r] = sd.ovf[r] ? 17'h7FFF : 17'(d2_quo[r][DB]);
            if (sd.neg[r])
                rv[r] = -rv[r];
        end
        cos_next[0] = sd.f.lock ? 17'($signed(sd.n2y)) : $signed(rv[0]);
        cos_next[1] = $signed(17'(sd.h));
        cos_next[2] = $signed(rv[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            cf_reg  <= d2_side_reg[DB-1].f;
        end
    end

    // arc cosine front end: clamp, sine by square root
    logic [14:0]      mag_next [3];
    logic [2:0]       cneg_next;
    logic [29:0]      c2_next [3];
    logic [2:0][14:0] mag_reg, mag2_reg;
    logic [2:0]       cneg_reg, cneg2_reg;
    logic [29:0]      c2_reg [3];
    logic [31:0]      rad_reg [3];
    flg_t             cf2_reg, cf3_reg;

    always_comb
    begin
        for (int u = 0; u < 3; u++)
        begin
            cneg_next[u] = cos_reg[u][16];
            if (cos_reg[u] > $signed(17'(rmte_pkg::ONE_Q14)) ||
                cos_reg[u] < -$signed(17'(rmte_pkg::ONE_Q14)))
                mag_next[u] = rmte_pkg::ONE_Q14;
            else if (cos_reg[u][16])
                mag_next[u] = 15'(-cos_reg[u]);
            else
                mag_next[u] = cos_reg[u][14:0];
            c2_next[u] = 30'(mag_next[u]) * 30'(mag_next[u]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int u = 0; u < 3; u++)
            begin
                mag_reg[u]  <= mag_next[u];
                c2_reg[u]   <= c2_next[u];
                mag2_reg[u] <= mag_reg[u];
                rad_reg[u]  <= rmte_pkg::ONE_SQ_Q28 - 32'(c2_reg[u]);
            end
            cneg_reg  <= cneg_next;
            cneg2_reg <= cneg_reg;
            cf2_reg   <= cf_reg;
            cf3_reg   <= cf2_reg;
        end
    end

    logic [OW-1:0] s3_op   [3][SQ+1];
    logic [RW-1:0] s3_rem  [3][SQ+1];
    logic [TW-1:0] s3_root [3][SQ+1];
    aside_t        s3_side_reg [SQ];

    for (genvar u = 0; u < 3; u++)
    begin : g_sine
        assign s3_op[u][0]   = rad_reg[u];
        assign s3_rem[u][0]  = '0;
        assign s3_root[u][0] = '0;
        for (genvar i = 0; i < SQ; i++)
        begin : g_cell
            rmte_sqrt_cell u_cell (
                .clk      (clk),
                .en       (en),
                .op_in    (s3_op[u][i]),
                .rem_in   (s3_rem[u][i]),
                .root_in  (s3_root[u][i]),
                .op_out   (s3_op[u][i+1]),
                .rem_out  (s3_rem[u][i+1]),
                .root_out (s3_root[u][i+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg[0] <= '{f: cf3_reg, mag: mag2_reg, cneg: cneg2_reg};
            for (int i = 1; i < SQ; i++)
                s3_side_reg[i] <= s3_side_reg[i-1];
        end
    end

    // CORDIC vectoring chain
    logic signed [XW-1:0] cx [3][CORDIC_STEPS+1];
    logic signed [XW-1:0] cy [3][CORDIC_STEPS+1];
    logic signed [ZW-1:0] cz [3][CORDIC_STEPS+1];
    logic signed [XW-1:0] cx0_reg [3];
    logic signed [XW-1:0] cy0_reg [3];
    cside_t               cs_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int u = 0; u < 3; u++)
            begin
                cx0_reg[u] <= $signed(XW'({s3_side_reg[SQ-1].mag[u], 16'b0}));
                cy0_reg[u] <= $signed(XW'({s3_root[u][SQ], 16'b0}));
            end
            cs_reg[0] <= '{f: s3_side_reg[SQ-1].f, cneg: s3_side_reg[SQ-1].cneg};
            for (int i = 1; i <= CORDIC_STEPS; i++)
                cs_reg[i] <= cs_reg[i-1];
        end
    end

    for (genvar u = 0; u < 3; u++)
    begin : g_cordic
        assign cx[u][0] = cx0_reg[u];
        assign cy[u][0] = cy0_reg[u];
        assign cz[u][0] = '0;
        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_cell
            rmte_cordic_cell #(.I(i)) u_cell (
                .clk   (clk),
                .en    (en),
                .x_in  (cx[u][i]),
                .y_in  (cy[u][i]),
                .z_in  (cz[u][i]),
                .x_out (cx[u][i+1]),
                .y_out (cy[u][i+1]),
                .z_out (cz[u][i+1])
            );
        end
    end

    // angle finish and output
    logic [13:0] acos_next [3];
    logic [13:0] acos_reg  [3];
    flg_t        ff_reg;

    always_comb
    begin
        logic [23:0] zc;
        logic [24:0] zr;
        for (int u = 0; u < 3; u++)
        begin
            if (cz[u][CORDIC_STEPS] < 0)
                zc = '0;
            else if (cz[u][CORDIC_STEPS] > $signed(ZW'(rmte_pkg::QUARTER_TURN)))
                zc = rmte_pkg::QUARTER_TURN;
            else
                zc = cz[u][CORDIC_STEPS][23:0];
            if (cs_reg[CORDIC_STEPS].cneg[u])
                zc = rmte_pkg::HALF_TURN - zc;
            zr = 25'(zc) + rmte_pkg::ROUND_HALF;
            acos_next[u] = zr[23:10];
        end
    end

    logic              ok_reg;
    logic signed [AW-1:0] ax_reg, ay_reg, az_reg;
    logic signed [AW-1:0] ax_next, ay_next, az_next;
    logic signed [AW-1:0] ag, ab, aa;

    always_comb
    begin
        ag = $signed(AW'(acos_reg[0]));
        ab = $signed(AW'(acos_reg[1]));
        aa = $signed(AW'(acos_reg[2]));
        ax_next = '0;
        ay_next = '0;
        az_next = '0;
        if (!ff_reg.bad)
        begin
            if (ff_reg.lock)
            begin
                ax_next = '0;
                if (!ff_reg.n1z_zero)
                    ay_next = ff_reg.n1z_neg ? $signed(rmte_pkg::LOCK_BETA)
                                             : -$signed(rmte_pkg::LOCK_BETA);
                if (!ff_reg.n2x_zero)
                    az_next = ff_reg.n2x_neg ? ag : -ag;
            end
            else
            begin
                az_next = ff_reg.n1y_neg ? -ag : ag;
                ay_next = ff_reg.n1z_neg ? ab : -ab;
                ax_next = ff_reg.n2z_neg ? -aa : aa;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acos_reg <= acos_next;
            ff_reg   <= cs_reg[CORDIC_STEPS].f;
            ok_reg   <= !ff_reg.bad;
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            az_reg   <= az_next;
        end
    end

    assign angles.ok      = ok_reg;
    assign angles.angle_x = ax_reg;
    assign angles.angle_y = ay_reg;
    assign angles.angle_z = az_reg;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid && !angles.ok |-> ax_reg == 0 && ay_reg == 0 && az_reg == 0)
        else $error("rejected matrix with nonzero angles");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid && angles.ok |->
            ax_reg >= -11520 && ax_reg <= 11520 && ay_reg >= -11520 &&
            ay_reg <= 11520 && az_reg >= -11520 && az_reg <= 11520)
        else $error("angle out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid && !angles.ready |=> $stable(vld_reg))
        else $error("chain moved during stall");

    a_no_take_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        angles.valid && !angles.ready |-> !matrix.ready)
        else $error("request taken while result stalled");

endmodule

>>> dv/rotation_matrix_to_euler_angles_tb.sv
module rotation_matrix_to_euler_angles_tb;

    localparam int ROT_STEPS = 16;
    localparam int LATENCY   = 92 + ROT_STEPS;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [rmte_pkg::COMP_W-1:0] c [9];
    } matrix_t;

    typedef struct packed {
        logic                                ok;
        logic signed [rmte_pkg::ANGLE_W-1:0] alpha;
        logic signed [rmte_pkg::ANGLE_W-1:0] beta;
        logic signed [rmte_pkg::ANGLE_W-1:0] gamma;
    } angles_t;

    class euler_scoreboard;
        longint  eps;
        angles_t expected_q [$];
        int      errors;

        function new();
            eps = 2;
            errors = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint round_div(longint num, longint den);
            longint m, q;
            m = (num < 0) ? -num : num;
            q = (2 * m + den) / (2 * den);
            return (num < 0) ? -q : q;
        endfunction

        function longint signum(longint v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        // arc cosine of a Q1.14 cosine, in 1/64 degree
        function longint arc_cos(longint c);
            longint atan_q16 [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                      58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                      229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
            longint s, x, y, z, t;
            if (c > 16384)
                c = 16384;
            if (c < -16384)
                c = -16384;
            s = longint'(int_sqrt(64'd268435456 - c * c));
            x = ((c < 0) ? -c : c) * 65536;
            y = s * 65536;
            z = 0;
            for (int i = 0; i < ROT_STEPS && i < 24; i++)
            begin
                t = x;
                if (y > 0)
                begin
                    x += y >>> i;
                    y -= t >>> i;
                    z += atan_q16[i];
                end
                else
                begin
                    x -= y >>> i;
                    y += t >>> i;
                    z -= atan_q16[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > 90 * 65536)
                z = 90 * 65536;
            if (c < 0)
                z = 180 * 65536 - z;
            return (z + 512) / 1024;
        endfunction

        function angles_t solve_angles(matrix_t m);
            longint v [3][3];
            longint n [3][3];
            longint len, dot, h, a, b, g;
            int k;
            angles_t r;
            bit good;
            good = 1;
            r = '0;
            for (int i = 0; i < 9; i++)
                v[i / 3][i % 3] = longint'(m.c[i]);
            for (int i = 0; i < 3 && good; i++)
            begin
                len = longint'(int_sqrt(v[i][0] * v[i][0] + v[i][1] * v[i][1]
                                        + v[i][2] * v[i][2]));
                if (len <= eps || len == 0)
                    good = 0;
                else
                    for (int j = 0; j < 3; j++)
                        n[i][j] = round_div(v[i][j] * 16384, len);
            end
            for (int i = 0; i < 3 && good; i++)
            begin
                k = (i + 1) % 3;
                dot = n[i][0] * n[k][0] + n[i][1] * n[k][1] + n[i][2] * n[k][2];
                if (dot < 0)
                    dot = -dot;
                if (dot > eps * 16384)
                    good = 0;
            end
            if (!good)
                return r;
            h = longint'(int_sqrt(n[0][0] * n[0][0] + n[0][1] * n[0][1]));
            if (h < eps || h == 0)
            begin
                a = 0;
                b = -90 * 64 * signum(n[0][2]);
                g = arc_cos(n[1][1]) * -signum(n[1][0]);
            end
            else
            begin
                g = arc_cos(round_div(n[0][0] * 16384, h));
                if (n[0][1] < 0)
                    g = -g;
                b = -arc_cos(h);
                if (n[0][2] < 0)
                    b = -b;
                a = arc_cos(round_div(n[2][2] * 16384, h));
                if (n[1][2] < 0)
                    a = -a;
            end
            r.ok = 1'b1;
            r.alpha = a[rmte_pkg::ANGLE_W-1:0];
            r.beta = b[rmte_pkg::ANGLE_W-1:0];
            r.gamma = g[rmte_pkg::ANGLE_W-1:0];
            return r;
        endfunction

        function void note_request(matrix_t m);
            expected_q.push_back(solve_angles(m));
        endfunction

        function void check_angles(angles_t got);
            angles_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result ok=%0d x=%0d y=%0d z=%0d",
                             got.ok, got.alpha, got.beta, got.gamma);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp ok=%0d x=%0d y=%0d z=%0d, got ok=%0d x=%0d y=%0d z=%0d",
                             want.ok, want.alpha, want.beta, want.gamma,
                             got.ok, got.alpha, got.beta, got.gamma);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rmte_pkg::EPS_W-1:0] cfg_wdata = '0;
    bit idle_en = 1;
    int stall_cycles = 0;

    rmte_matrix_if req_if ();
    rmte_angles_if ang_if ();

    euler_scoreboard sb = new();

    rotation_matrix_to_euler_angles u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .matrix    (req_if),
        .angles    (ang_if)
    );

    always #1 clk = ~clk;

    initial
    begin
        req_if.valid = 1'b0;
        req_if.first_x = '0;
        req_if.first_y = '0;
        req_if.first_z = '0;
        req_if.second_x = '0;
        req_if.second_y = '0;
        req_if.second_z = '0;
        req_if.third_x = '0;
        req_if.third_y = '0;
        req_if.third_z = '0;
        ang_if.ready = 1'b0;
    end

    always @(negedge clk)
        ang_if.ready <= !(idle_en && $urandom_range(99) < 8);

    always @(posedge clk)
    begin
        if (ang_if.valid && ang_if.ready)
            sb.check_angles({ang_if.ok, ang_if.angle_x, ang_if.angle_y, ang_if.angle_z});
        if ((ang_if.valid && ang_if.ready) || (req_if.valid && req_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL rotation_matrix_to_euler_angles");
            $finish;
        end
    end

    task automatic send_matrix(matrix_t m);
        while (idle_en && $urandom_range(99) < 8)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.first_x <= m.c[0];
        req_if.first_y <= m.c[1];
        req_if.first_z <= m.c[2];
        req_if.second_x <= m.c[3];
        req_if.second_y <= m.c[4];
        req_if.second_z <= m.c[5];
        req_if.third_x <= m.c[6];
        req_if.third_y <= m.c[7];
        req_if.third_z <= m.c[8];
        req_if.valid <= 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(m);
        @(negedge clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 12) @(negedge clk);
    endtask

    task automatic write_epsilon(int unsigned value);
        cfg_we <= 1'b1;
        cfg_wdata <= value[rmte_pkg::EPS_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.eps = value;
        @(negedge clk);
    endtask

    function automatic logic signed [rmte_pkg::COMP_W-1:0] to_comp(real val, int jitter);
        int q;
        q = $rtoi(val * 16384.0 + ((val < 0.0) ? -0.5 : 0.5)) + jitter;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[rmte_pkg::COMP_W-1:0];
    endfunction

    function automatic matrix_t make_matrix(int c0, int c1, int c2, int c3, int c4,
                                            int c5, int c6, int c7, int c8);
        matrix_t m;
        m.c = '{c0[15:0], c1[15:0], c2[15:0], c3[15:0], c4[15:0], c5[15:0],
                c6[15:0], c7[15:0], c8[15:0]};
        return m;
    endfunction

    function automatic matrix_t random_rotation();
        real deg, a, b, g, sa, ca, sb_, cb, sg, cg, scale;
        real e [9];
        int spread;
        matrix_t m;
        deg = 3.14159265358979 / 180.0;
        a = ($urandom_range(36000) / 100.0 - 180.0) * deg;
        g = ($urandom_range(36000) / 100.0 - 180.0) * deg;
        case ($urandom_range(7))
            0:       b = 90.0 * deg;
            1:       b = -90.0 * deg;
            2:       b = (($urandom_range(1) != 0) ? 89.99 : -89.99) * deg;
            default: b = ($urandom_range(18000) / 100.0 - 90.0) * deg;
        endcase
        sa = $sin(a); ca = $cos(a);
        sb_ = $sin(b); cb = $cos(b);
        sg = $sin(g); cg = $cos(g);
        e = '{cb * cg, cb * sg, -sb_,
              sa * sb_ * cg - ca * sg, sa * sb_ * sg + ca * cg, sa * cb,
              ca * sb_ * cg + sa * sg, ca * sb_ * sg - sa * cg, ca * cb};
        scale = ($urandom_range(9) == 0) ? $urandom_range(1, 20) / 16384.0
                                         : $urandom_range(20, 199) / 100.0;
        spread = ($urandom_range(9) == 0) ? 300 : 2;
        for (int i = 0; i < 9; i++)
            m.c[i] = to_comp(e[i] * scale, $urandom_range(2 * spread) - spread);
        return m;
    endfunction

    function automatic matrix_t random_raw();
        matrix_t m;
        logic [31:0] rv;
        for (int i = 0; i < 9; i++)
        begin
            rv = $urandom;
            m.c[i] = rv[rmte_pkg::COMP_W-1:0];
        end
        return m;
    endfunction

    task automatic run_directed();
        send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767));
        send_matrix(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768));
        send_matrix(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_matrix(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_matrix(make_matrix(32767, 0, 0, 0, -32768, 0, 0, 0, 32767));
        send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(make_matrix(3, 0, 0, 0, 3, 0, 0, 0, 3));
        send_matrix(make_matrix(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
        send_matrix(make_matrix(0, 0, -16384, 0, 16384, 0, 16384, 0, 0));
        send_matrix(make_matrix(0, 0, 16384, -16384, 0, 0, 0, -16384, 0));
        send_matrix(make_matrix(0, 0, -16384, 16384, 0, 0, 0, 16384, 0));
        send_matrix(make_matrix(0, 0, 16384, 0, -16384, 0, 16384, 0, 0));
        send_matrix(make_matrix(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
        send_matrix(make_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, -16384));
        send_matrix(make_matrix(11585, 11585, 0, -11585, 11585, 0, 0, 0, 16384));
        send_matrix(make_matrix(16384, 16384, 0, 0, 0, 16384, 16384, -16384, 0));
        send_matrix(make_matrix(16384, 0, 0, 0, 0, 0, 0, 0, 16384));
        send_matrix(make_matrix(0, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_matrix(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 0));
    endtask

    initial
    begin
        int unsigned eps_list [7];
        eps_list = '{0, 2, 16383, 1, 40, 0, 0};
        eps_list[5] = $urandom_range(16383);
        eps_list[6] = $urandom_range(3, 300);
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            write_epsilon(eps_list[ph]);
            idle_en = (ph != 3);
            if (ph < 2)
                run_directed();
            for (int i = 0; i < 180; i++)
                send_matrix(($urandom_range(99) < 80) ? random_rotation() : random_raw());
        end
        idle_en = 1;
        drain();
        if (sb.errors == 0)
            $display("PASS rotation_matrix_to_euler_angles");
        else
            $display("FAIL rotation_matrix_to_euler_angles");
        $finish;
    end

endmodule
